>>> hw/rtl/apd_pkg.sv
package apd_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_BITS = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHABET_MODE         = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INCLUDE_TERMINAL_GAPS = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENALIZE_GAP_GAP      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENALIZE_GAP_LETTER   = 8'd3;

    // result status codes
    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_NO_OVERLAP_1 = 3'd1;
    localparam logic [2:0] STATUS_NO_OVERLAP_U = 3'd2;
    localparam logic [2:0] STATUS_ZERO_LENGTH  = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW     = 3'd4;

    // symbol codes
    localparam logic [7:0] NT_GAP_DASH = 8'h10;
    localparam logic [7:0] NT_GAP_DOT  = 8'h40;
    localparam logic [7:0] NT_GAP_MASK = 8'h50;
    localparam logic [7:0] AA_DASH     = 8'h2D;
    localparam logic [7:0] AA_DOT      = 8'h2E;
    localparam logic [7:0] AA_X        = 8'h58;
    localparam logic [7:0] AA_PLUS     = 8'h2B;
    localparam logic [7:0] AA_STAR     = 8'h2A;
    localparam logic [7:0] AA_B        = 8'h42;
    localparam logic [7:0] AA_N        = 8'h4E;
    localparam logic [7:0] AA_D        = 8'h44;
    localparam logic [7:0] AA_J        = 8'h4A;
    localparam logic [7:0] AA_I        = 8'h49;
    localparam logic [7:0] AA_L        = 8'h4C;
    localparam logic [7:0] AA_Z        = 8'h5A;
    localparam logic [7:0] AA_Q        = 8'h51;
    localparam logic [7:0] AA_E        = 8'h45;

    localparam logic [16:0] DIST_ONE = 17'h10000;

    typedef enum logic [1:0] {
        CLASS_MATCH,
        CLASS_MISMATCH,
        CLASS_GAP_GAP,
        CLASS_GAP_LETTER
    } class_t;

    typedef struct packed {
        logic [7:0] symbol_a;
        logic [7:0] symbol_b;
        logic       last_column;
    } in_item_t;

    typedef struct packed {
        logic [15:0] mismatch_count;
        logic [15:0] effective_length;
        logic [16:0] distance_q16;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [15:0] numerator;
        logic [15:0] denominator;
    } div_request_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } div_result_t;

    function automatic logic is_gap(input logic [7:0] x, input logic amino);
        if (amino)
            return (x == AA_DASH) || (x == AA_DOT);
        return (x & NT_GAP_MASK) != 8'h00;
    endfunction

    function automatic logic aa_pair(input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] p, input logic [7:0] q1,
                                     input logic [7:0] q2);
        return (x == p && (y == q1 || y == q2)) || (y == p && (x == q1 || x == q2));
    endfunction

    function automatic logic x_wild(input logic [7:0] x, input logic [7:0] y);
        return (x == AA_X) && !(y == AA_DASH || y == AA_PLUS || y == AA_STAR);
    endfunction

    function automatic class_t classify(input logic [7:0] a, input logic [7:0] b,
                                        input logic amino);
        logic same;
        logic [7:0] both;
        both = a & b;
        if (amino) begin
            same = (a == b) || x_wild(a, b) || x_wild(b, a) ||
                   aa_pair(a, b, AA_B, AA_N, AA_D) ||
                   aa_pair(a, b, AA_J, AA_I, AA_L) ||
                   aa_pair(a, b, AA_Z, AA_Q, AA_E);
            if (!same) begin
                if ((a == AA_DASH && b == AA_DOT) || (a == AA_DOT && b == AA_DASH))
                    return CLASS_GAP_GAP;
                if (is_gap(a, 1'b1) || is_gap(b, 1'b1))
                    return CLASS_GAP_LETTER;
                return CLASS_MISMATCH;
            end
            if ((a == AA_DASH && b == AA_DASH) || (a == AA_DOT && b == AA_DOT))
                return CLASS_GAP_GAP;
            return CLASS_MATCH;
        end
        if (both == 8'h00) begin
            if (((a & NT_GAP_DOT) != 8'h00 && (b & NT_GAP_DASH) != 8'h00) ||
                ((a & NT_GAP_DASH) != 8'h00 && (b & NT_GAP_DOT) != 8'h00))
                return CLASS_GAP_GAP;
            if (((a | b) & NT_GAP_MASK) != 8'h00)
                return CLASS_GAP_LETTER;
            return CLASS_MISMATCH;
        end
        if ((both & NT_GAP_MASK) != 8'h00)
            return CLASS_GAP_GAP;
        return CLASS_MATCH;
    endfunction

endpackage

>>> hw/rtl/apd_divider.sv
// Restoring divider: quotient = floor(numerator * 2^16 / denominator).
// Needs numerator <= denominator and denominator != 0; one bit per cycle.
module apd_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  apd_pkg::div_request_t req,
    output apd_pkg::div_result_t  res
);

    logic [16:0] rem_reg;
    logic [16:0] rem_next;
    logic [16:0] quo_reg;
    logic [16:0] quo_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [16:0] rem_shift;
    logic        fits;
    logic        top_bit;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        top_bit   = req.numerator >= req.denominator;
        rem_shift = {rem_reg[15:0], 1'b0};
        fits      = rem_shift >= {1'b0, req.denominator};
        if (req.start)
        begin
            // integer part of the quotient is 0 or 1
            rem_next  = top_bit ? {1'b0, req.numerator - req.denominator}
                                : {1'b0, req.numerator};
            quo_next  = {16'h0000, top_bit};
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_shift - {1'b0, req.denominator} : rem_shift;
            quo_next = {quo_reg[15:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

>>> hw/rtl/aligned_pair_distance_unit.sv
// Aligned pair distance unit.
// The in channel takes one alignment column per request (two symbols and a
// last-column mark); columns stream in at one per cycle while in_ready is
// high. The cfg port writes the four 1-bit mode registers; write them only
// between sequences. On the column marked last the block stops taking
// requests, picks the compared region and status in its finish state,
// then, for an ok status, runs the shift-subtract divider to form the Q16
// distance, which passes through the hold state to the output register.
// The result sits in an output register; while the receiver stalls, columns
// of the next sequence are still taken, and the next result waits, with
// requests held off, for the register to free up. Reset clears the stream
// state, the mode registers and the output valid; after each result the
// stream state is cleared and the mode registers keep their values.
module aligned_pair_distance_unit #(
    parameter int COUNT_BITS = apd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  apd_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output apd_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [apd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic                                cfg_data
);

    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FINISH,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic amino_reg;
    logic itg_reg;
    logic pgg_reg;
    logic pgl_reg;

    logic [CW-1:0] col_reg,    col_next;
    logic          seen_a_reg, seen_a_next;
    logic          seen_b_reg, seen_b_next;
    logic [CW-1:0] cov_reg,    cov_next;
    logic [CW-1:0] mism_reg,   mism_next;
    logic [CW-1:0] drop_reg,   drop_next;
    logic [CW-1:0] sa_cov_reg, sa_cov_next;
    logic [CW-1:0] sa_mis_reg, sa_mis_next;
    logic [CW-1:0] sa_drp_reg, sa_drp_next;
    logic          sa_both_reg, sa_both_next;
    logic [CW-1:0] sb_cov_reg, sb_cov_next;
    logic [CW-1:0] sb_mis_reg, sb_mis_next;
    logic [CW-1:0] sb_drp_reg, sb_drp_next;
    logic          sb_both_reg, sb_both_next;
    logic [CW-1:0] pos_a_reg,  pos_a_next;
    logic [CW-1:0] pos_b_reg,  pos_b_next;
    logic          ovf_reg,    ovf_next;

    logic [15:0] res_mism_reg;
    logic [15:0] res_eff_reg;
    logic [16:0] res_dist_reg;
    logic [2:0]  res_status_reg;

    apd_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    apd_pkg::div_request_t div_req;
    apd_pkg::div_result_t  div_res;

    // column path
    logic            accept;
    logic            let_a;
    logic            let_b;
    logic            seen_a_c;
    logic            seen_b_c;
    logic            count_en;
    apd_pkg::class_t kind;
    logic            inc_mism;
    logic            inc_drop;
    logic [CW-1:0]   cov_c;
    logic [CW-1:0]   mism_c;
    logic [CW-1:0]   drop_c;
    logic            bump_ovf;

    // finish path
    logic          first_a;
    logic [CW-1:0] fe_cov;
    logic [CW-1:0] fe_mis;
    logic [CW-1:0] fe_drp;
    logic          fe_both;
    logic [CW-1:0] use_cov;
    logic [CW-1:0] use_mis;
    logic [CW-1:0] use_drp;
    logic          overlap;
    logic [CW-1:0] eff_w;
    logic [31:0]   eff32;
    logic [31:0]   mis32;
    logic [2:0]    fin_status;
    logic          out_free;

    assign in_ready = (state_reg == ST_RUN);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        let_a    = !apd_pkg::is_gap(in_data.symbol_a, amino_reg);
        let_b    = !apd_pkg::is_gap(in_data.symbol_b, amino_reg);
        seen_a_c = seen_a_reg || let_a;
        seen_b_c = seen_b_reg || let_b;
        count_en = itg_reg || (seen_a_c && seen_b_c);
        kind     = apd_pkg::classify(in_data.symbol_a, in_data.symbol_b, amino_reg);
        inc_mism = (kind == apd_pkg::CLASS_MISMATCH) ||
                   (kind == apd_pkg::CLASS_GAP_GAP && pgg_reg) ||
                   (kind == apd_pkg::CLASS_GAP_LETTER && pgl_reg);
        inc_drop = (kind == apd_pkg::CLASS_GAP_GAP && !pgg_reg) ||
                   (kind == apd_pkg::CLASS_GAP_LETTER && !pgl_reg);
        cov_c    = cov_reg;
        mism_c   = mism_reg;
        drop_c   = drop_reg;
        bump_ovf = 1'b0;
        if (count_en)
        begin
            // saturating counters; a full one flags overflow
            if (cov_reg == CNT_MAX)
                bump_ovf = 1'b1;
            else
                cov_c = cov_reg + 1'b1;
            if (inc_mism)
            begin
                if (mism_reg == CNT_MAX)
                    bump_ovf = 1'b1;
                else
                    mism_c = mism_reg + 1'b1;
            end
            if (inc_drop)
            begin
                if (drop_reg == CNT_MAX)
                    bump_ovf = 1'b1;
                else
                    drop_c = drop_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        first_a = pos_a_reg <= pos_b_reg;
        fe_cov  = first_a ? sa_cov_reg  : sb_cov_reg;
        fe_mis  = first_a ? sa_mis_reg  : sb_mis_reg;
        fe_drp  = first_a ? sa_drp_reg  : sb_drp_reg;
        fe_both = first_a ? sa_both_reg : sb_both_reg;
        use_cov = itg_reg ? cov_reg  : fe_cov;
        use_mis = itg_reg ? mism_reg : fe_mis;
        use_drp = itg_reg ? drop_reg : fe_drp;
        overlap = seen_a_reg && seen_b_reg && fe_both;
        eff_w   = (use_drp > use_cov) ? '0 : use_cov - use_drp;
        eff32   = 32'(eff_w);
        mis32   = 32'(use_mis);
        if (ovf_reg || eff32[31:16] != 16'h0000 || mis32[31:16] != 16'h0000 ||
            use_mis > eff_w)
            fin_status = apd_pkg::STATUS_OVERFLOW;
        else if (!overlap)
            fin_status = itg_reg ? apd_pkg::STATUS_NO_OVERLAP_1
                                 : apd_pkg::STATUS_NO_OVERLAP_U;
        else if (eff_w == '0)
            fin_status = apd_pkg::STATUS_ZERO_LENGTH;
        else
            fin_status = apd_pkg::STATUS_OK;
    end

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        seen_a_next  = seen_a_reg;
        seen_b_next  = seen_b_reg;
        cov_next     = cov_reg;
        mism_next    = mism_reg;
        drop_next    = drop_reg;
        sa_cov_next  = sa_cov_reg;
        sa_mis_next  = sa_mis_reg;
        sa_drp_next  = sa_drp_reg;
        sa_both_next = sa_both_reg;
        sb_cov_next  = sb_cov_reg;
        sb_mis_next  = sb_mis_reg;
        sb_drp_next  = sb_drp_reg;
        sb_both_next = sb_both_reg;
        pos_a_next   = pos_a_reg;
        pos_b_next   = pos_b_reg;
        ovf_next     = ovf_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    seen_a_next = seen_a_c;
                    seen_b_next = seen_b_c;
                    cov_next    = cov_c;
                    mism_next   = mism_c;
                    drop_next   = drop_c;
                    ovf_next    = ovf_reg || bump_ovf;
                    if (let_a)
                    begin
                        sa_cov_next  = cov_c;
                        sa_mis_next  = mism_c;
                        sa_drp_next  = drop_c;
                        sa_both_next = seen_a_c && seen_b_c;
                        pos_a_next   = col_reg;
                    end
                    if (let_b)
                    begin
                        sb_cov_next  = cov_c;
                        sb_mis_next  = mism_c;
                        sb_drp_next  = drop_c;
                        sb_both_next = seen_a_c && seen_b_c;
                        pos_b_next   = col_reg;
                    end
                    if (in_data.last_column)
                        state_next = ST_FINISH;
                    else if (col_reg == CNT_MAX)
                        ovf_next = 1'b1;
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // result fields are latched this cycle; stream state clears
                col_next     = '0;
                seen_a_next  = 1'b0;
                seen_b_next  = 1'b0;
                cov_next     = '0;
                mism_next    = '0;
                drop_next    = '0;
                sa_cov_next  = '0;
                sa_mis_next  = '0;
                sa_drp_next  = '0;
                sa_both_next = 1'b0;
                sb_cov_next  = '0;
                sb_mis_next  = '0;
                sb_drp_next  = '0;
                sb_both_next = 1'b0;
                pos_a_next   = '0;
                pos_b_next   = '0;
                ovf_next     = 1'b0;
                state_next   = (fin_status == apd_pkg::STATUS_OK) ? ST_DIV : ST_HOLD;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign div_req.start       = (state_reg == ST_FINISH) &&
                                 (fin_status == apd_pkg::STATUS_OK);
    assign div_req.numerator   = (state_reg == ST_FINISH) ? mis32[15:0] : res_mism_reg;
    assign div_req.denominator = (state_reg == ST_FINISH) ? eff32[15:0] : res_eff_reg;

    apd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            amino_reg     <= 1'b0;
            itg_reg       <= 1'b0;
            pgg_reg       <= 1'b0;
            pgl_reg       <= 1'b0;
            col_reg       <= '0;
            seen_a_reg    <= 1'b0;
            seen_b_reg    <= 1'b0;
            cov_reg       <= '0;
            mism_reg      <= '0;
            drop_reg      <= '0;
            sa_cov_reg    <= '0;
            sa_mis_reg    <= '0;
            sa_drp_reg    <= '0;
            sa_both_reg   <= 1'b0;
            sb_cov_reg    <= '0;
            sb_mis_reg    <= '0;
            sb_drp_reg    <= '0;
            sb_both_reg   <= 1'b0;
            pos_a_reg     <= '0;
            pos_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            seen_a_reg  <= seen_a_next;
            seen_b_reg  <= seen_b_next;
            cov_reg     <= cov_next;
            mism_reg    <= mism_next;
            drop_reg    <= drop_next;
            sa_cov_reg  <= sa_cov_next;
            sa_mis_reg  <= sa_mis_next;
            sa_drp_reg  <= sa_drp_next;
            sa_both_reg <= sa_both_next;
            sb_cov_reg  <= sb_cov_next;
            sb_mis_reg  <= sb_mis_next;
            sb_drp_reg  <= sb_drp_next;
            sb_both_reg <= sb_both_next;
            pos_a_reg   <= pos_a_next;
            pos_b_reg   <= pos_b_next;
            ovf_reg     <= ovf_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    apd_pkg::CFG_ALPHABET_MODE:         amino_reg <= cfg_data;
                    apd_pkg::CFG_INCLUDE_TERMINAL_GAPS: itg_reg   <= cfg_data;
                    apd_pkg::CFG_PENALIZE_GAP_GAP:      pgg_reg   <= cfg_data;
                    apd_pkg::CFG_PENALIZE_GAP_LETTER:   pgl_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_HOLD && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            res_status_reg <= fin_status;
            if (fin_status == apd_pkg::STATUS_OK)
            begin
                res_mism_reg <= mis32[15:0];
                res_eff_reg  <= eff32[15:0];
                res_dist_reg <= 17'h00000;
            end
            else
            begin
                res_mism_reg <= 16'h0000;
                res_eff_reg  <= 16'h0000;
                res_dist_reg <= (fin_status == apd_pkg::STATUS_NO_OVERLAP_1)
                                ? apd_pkg::DIST_ONE : 17'h00000;
            end
        end
        else if (state_reg == ST_DIV && div_res.done)
        begin
            res_dist_reg <= div_res.quotient;
        end
        if (state_reg == ST_HOLD && out_free)
        begin
            out_reg.mismatch_count   <= res_mism_reg;
            out_reg.effective_length <= res_eff_reg;
            out_reg.distance_q16     <= res_dist_reg;
            out_reg.status           <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
